// File: src/hpga_pkg.sv
// ----------------------------------------------------------------------------
// HEVC POC and GOP analyzer package
// Transfer payload types, the control bundle between the pipeline and the GOP
// tracker, and the fixed codes of the frame header fields.
// ----------------------------------------------------------------------------
package hpga_pkg;

   typedef struct packed {
      logic        op;
      logic        is_idr;
      logic [1:0]  pic_class;
      logic [5:0]  nal_code;
      logic [2:0]  temporal_id;
      logic [15:0] poc_lsb;
   } req_type;

   typedef struct packed {
      logic signed [31:0] poc;
      logic [7:0]         entry_flags;
      logic [7:0]         max_b_run;
      logic [15:0]        max_gop_size;
      logic               gop_unlimited;
      logic               closed_gop;
      logic               identical_gop;
      logic               starts_with_intra;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  max_b_run;
      logic [15:0] max_gop_size;
      logic        gop_unlimited;
      logic        closed_gop;
      logic        identical_gop;
      logic        starts_with_intra;
   } stats_type;

   typedef struct packed {
      logic accept;   // a request transfer enters the input stage
      logic commit;   // the input stage item updates the state
   } ctl_type;

   localparam logic OP_FRAME = 1'b0;
   localparam logic OP_EOS   = 1'b1;

   localparam logic [1:0] FT_I       = 2'd0;
   localparam logic [1:0] FT_P       = 2'd1;
   localparam logic [1:0] FT_B       = 2'd2;
   localparam logic [1:0] FT_UNKNOWN = 2'd3;

   localparam logic [1:0] PRED_I = 2'd0;
   localparam logic [1:0] PRED_P = 2'd2;
   localparam logic [1:0] PRED_B = 2'd3;

   localparam logic [7:0] FLAG_IDR = 8'h84;

   localparam logic [5:0] NAL_RADL_N   = 6'd6;
   localparam logic [5:0] NAL_RADL_R   = 6'd7;
   localparam logic [5:0] NAL_RASL_N   = 6'd8;
   localparam logic [5:0] NAL_RASL_R   = 6'd9;
   localparam logic [5:0] NAL_SLNR_MAX = 6'd14;

   localparam logic [4:0] LOG2_POC_RESET  = 5'd8;
   localparam logic [4:0] LOG2_POC_BAD    = 5'd31;
   localparam logic [4:0] LOG2_POC_NOWRAP = 5'd17;

   localparam logic [7:0]  B_RUN_LIMIT    = 8'hFF;
   localparam logic [31:0] GOP_SIZE_LIMIT = 32'd65535;
   localparam logic [31:0] FRAME_POS_MAX  = 32'hFFFF_FFFF;

   // Unknown frame types count as intra.
   function automatic logic [1:0] norm_type(input logic [1:0] ft);
      logic [1:0] res;
      begin
         res = (ft == FT_UNKNOWN) ? FT_I : ft;
         return res;
      end
   endfunction

endpackage

// File: src/hpga_poc_unit.sv
// ----------------------------------------------------------------------------
// HEVC picture order count decoder
// Derives the POC MSB from the previous reference picture and keeps the
// previous-POC state that TemporalId-0 reference pictures update.
// ----------------------------------------------------------------------------
module hpga_poc_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             commit,
   input  hpga_pkg::req_type item,
   input  logic [4:0]       log2_max_poc_lsb,
   output logic [31:0]      poc
);

   logic [15:0] prev_lsb_ff, prev_lsb_in;
   logic [31:0] prev_msb_ff, prev_msb_in;
   logic        have_prev_ff, have_prev_in;

   logic        frame;
   logic        mod_ok;
   logic        no_wrap;
   logic [31:0] modulus;
   logic [4:0]  half_sh;
   logic [16:0] half;
   logic [15:0] d_down;
   logic [15:0] d_up;
   logic        wrap_down;
   logic        wrap_up;
   logic [31:0] msb;
   logic        is_rasl;
   logic        is_radl;
   logic        is_slnr;
   logic        updates_prev;

   always_comb begin
      frame   = (item.op == hpga_pkg::OP_FRAME);
      mod_ok  = (log2_max_poc_lsb != 5'd0) && (log2_max_poc_lsb != hpga_pkg::LOG2_POC_BAD);
      // Beyond 2^17 the half modulus exceeds any 16-bit LSB difference.
      no_wrap = (log2_max_poc_lsb > hpga_pkg::LOG2_POC_NOWRAP);
      modulus = 32'd1 << log2_max_poc_lsb;
      half_sh = log2_max_poc_lsb - 5'd1;
      half    = 17'd1 << half_sh;
      d_down  = prev_lsb_ff - item.poc_lsb;
      d_up    = item.poc_lsb - prev_lsb_ff;

      wrap_down = (item.poc_lsb < prev_lsb_ff) && !no_wrap && ({1'b0, d_down} >= half);
      wrap_up   = (item.poc_lsb > prev_lsb_ff) && !no_wrap && ({1'b0, d_up} > half);

      if (!have_prev_ff || !mod_ok) begin
         msb = 32'd0;
      end else if (wrap_down) begin
         msb = prev_msb_ff + modulus;
      end else if (wrap_up) begin
         msb = prev_msb_ff - modulus;
      end else begin
         msb = prev_msb_ff;
      end

      is_rasl = (item.nal_code == hpga_pkg::NAL_RASL_N) ||
                (item.nal_code == hpga_pkg::NAL_RASL_R);
      is_radl = (item.nal_code == hpga_pkg::NAL_RADL_N) ||
                (item.nal_code == hpga_pkg::NAL_RADL_R);
      is_slnr = (item.nal_code <= hpga_pkg::NAL_SLNR_MAX) && !item.nal_code[0];
      updates_prev = (item.temporal_id == 3'd0) && !is_rasl && !is_radl && !is_slnr;

      if (!frame || item.is_idr) begin
         poc = 32'd0;
      end else begin
         poc = msb + {16'd0, item.poc_lsb};
      end

      prev_lsb_in  = prev_lsb_ff;
      prev_msb_in  = prev_msb_ff;
      have_prev_in = have_prev_ff;
      if (commit && frame) begin
         if (item.is_idr) begin
            prev_lsb_in  = 16'd0;
            prev_msb_in  = 32'd0;
            have_prev_in = 1'b1;
         end else if (updates_prev) begin
            prev_lsb_in  = item.poc_lsb;
            prev_msb_in  = msb;
            have_prev_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_lsb_ff  <= 16'd0;
         prev_msb_ff  <= 32'd0;
         have_prev_ff <= 1'b0;
      end else begin
         prev_lsb_ff  <= prev_lsb_in;
         prev_msb_ff  <= prev_msb_in;
         have_prev_ff <= have_prev_in;
      end
   end

endmodule

// File: src/hpga_gop_unit.sv
// ----------------------------------------------------------------------------
// HEVC GOP statistics tracker
// Keeps B-run, GOP size, closed and identical GOP marks, and stores the first
// GOP's frame types in a pattern memory that later GOPs are compared against.
// ----------------------------------------------------------------------------
module hpga_gop_unit #(
   parameter int unsigned DEPTH = 4096
) (
   input  logic               clock,
   input  logic               reset,
   input  hpga_pkg::ctl_type  ctl,
   input  logic [1:0]         req_pic_class,
   input  hpga_pkg::req_type  item,
   output hpga_pkg::stats_type stats_next
);

   localparam int unsigned AW = $clog2(DEPTH);
   localparam int unsigned LW = $clog2(DEPTH + 1);

   logic [31:0]   frame_pos_ff, frame_pos_in;
   // Distance from the current GOP start to the next frame position.
   logic [31:0]   offset_ff, offset_in;
   logic [7:0]    b_run_ff, b_run_in;
   logic [7:0]    b_max_ff, b_max_in;
   logic [15:0]   gop_max_ff, gop_max_in;
   logic          unlimited_ff, unlimited_in;
   logic          closed_ff, closed_in;
   logic          intra_ff, intra_in;
   logic          ident_ff, ident_in;
   logic          first_ff, first_in;
   logic [LW-1:0] len_ff, len_in;
   logic [1:0]    rd_data_ff;

   logic [1:0]    pattern_mem [0:DEPTH-1];

   logic          frame;
   logic [1:0]    ftype;
   logic          grp_start;
   logic          size_check;
   logic          pos_at_max;
   logic [31:0]   at;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd_addr;
   logic          req_grp_start;

   always_comb begin
      frame      = (item.op == hpga_pkg::OP_FRAME);
      ftype      = hpga_pkg::norm_type(item.pic_class);
      grp_start  = (ftype == hpga_pkg::FT_I);
      pos_at_max = (frame_pos_ff == hpga_pkg::FRAME_POS_MAX);
      at         = grp_start ? 32'd0 : offset_ff;

      frame_pos_in = frame_pos_ff;
      offset_in    = offset_ff;
      b_run_in     = b_run_ff;
      b_max_in     = b_max_ff;
      gop_max_in   = gop_max_ff;
      unlimited_in = unlimited_ff;
      closed_in    = closed_ff;
      intra_in     = intra_ff;
      ident_in     = ident_ff;
      first_in     = first_ff;
      len_in       = len_ff;
      wr_en        = 1'b0;
      wr_addr      = len_ff[AW-1:0];

      size_check = ctl.commit && (!frame || grp_start);
      if (size_check && !unlimited_ff) begin
         if (offset_ff > hpga_pkg::GOP_SIZE_LIMIT) begin
            unlimited_in = 1'b1;
            gop_max_in   = 16'd0;
         end else if (offset_ff[15:0] > gop_max_ff) begin
            gop_max_in = offset_ff[15:0];
         end
      end

      if (ctl.commit && frame) begin
         if (ftype == hpga_pkg::FT_B) begin
            if (b_run_ff != hpga_pkg::B_RUN_LIMIT) begin
               b_run_in = b_run_ff + 8'd1;
            end
            if (b_run_in > b_max_ff) begin
               b_max_in = b_run_in;
            end
         end else begin
            b_run_in = 8'd0;
         end

         if (grp_start && !item.is_idr) begin
            closed_in = 1'b0;
         end
         if ((frame_pos_ff == 32'd0) && !grp_start) begin
            intra_in = 1'b0;
         end
         if (!intra_in && grp_start) begin
            ident_in = 1'b0;
         end

         if (ident_in) begin
            if (first_ff && grp_start && (frame_pos_ff != 32'd0)) begin
               first_in = 1'b0;
            end
            if (first_in) begin
               if (len_ff < LW'(DEPTH)) begin
                  wr_en  = 1'b1;
                  len_in = len_ff + LW'(1);
               end
               if (len_in >= LW'(DEPTH)) begin
                  ident_in = 1'b0;
               end
            end else if ((at >= 32'(len_ff)) || (rd_data_ff != ftype)) begin
               ident_in = 1'b0;
            end
         end

         if (!pos_at_max) begin
            frame_pos_in = frame_pos_ff + 32'd1;
         end
         if (grp_start) begin
            offset_in = pos_at_max ? 32'd0 : 32'd1;
         end else if (!pos_at_max) begin
            offset_in = offset_ff + 32'd1;
         end
      end

      // The incoming item's pattern entry is fetched as it is accepted, at the offset this item leaves.
      req_grp_start = (hpga_pkg::norm_type(req_pic_class) == hpga_pkg::FT_I);
      if (req_grp_start || (offset_in >= 32'(DEPTH))) begin
         rd_addr = '0;
      end else begin
         rd_addr = offset_in[AW-1:0];
      end

      stats_next.max_b_run         = b_max_in;
      stats_next.max_gop_size      = gop_max_in;
      stats_next.gop_unlimited     = unlimited_in;
      stats_next.closed_gop        = closed_in;
      stats_next.identical_gop     = ident_in;
      stats_next.starts_with_intra = intra_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         pattern_mem[wr_addr] <= ftype;
      end
      if (ctl.accept) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= ftype;
         end else begin
            rd_data_ff <= pattern_mem[rd_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_pos_ff <= 32'd0;
         offset_ff    <= 32'd0;
         b_run_ff     <= 8'd0;
         b_max_ff     <= 8'd0;
         gop_max_ff   <= 16'd0;
         unlimited_ff <= 1'b0;
         closed_ff    <= 1'b1;
         intra_ff     <= 1'b1;
         ident_ff     <= 1'b1;
         first_ff     <= 1'b1;
         len_ff       <= '0;
      end else begin
         frame_pos_ff <= frame_pos_in;
         offset_ff    <= offset_in;
         b_run_ff     <= b_run_in;
         b_max_ff     <= b_max_in;
         gop_max_ff   <= gop_max_in;
         unlimited_ff <= unlimited_in;
         closed_ff    <= closed_in;
         intra_ff     <= intra_in;
         ident_ff     <= ident_in;
         first_ff     <= first_in;
         len_ff       <= len_in;
      end
   end

endmodule

// File: src/hevc_poc_gop_analyzer_unit.sv
// ----------------------------------------------------------------------------
// HEVC POC and GOP analyzer
// Decodes the picture order count of parsed frame headers and reports index
// flags and running GOP statistics, one response per request.
// ----------------------------------------------------------------------------
// Usage:
// Each request transfer carries one frame header (op coded frame) or an end
// of stream marker, which runs the final GOP size check. Every request gives
// exactly one response transfer, in order.
// A request accepted at one clock edge enters the input register; its
// response is loaded into the output register once the output side is free,
// which raises rsp_valid. Throughput is one item per cycle while rsp_stall
// stays low. The pattern memory has one read port, read ahead with the
// request, and one write port.
// When rsp_stall is high the response holds; the input register still takes
// one more request, then req_stall rises until the response moves on.
// Reset clears all statistics and the POC history; the LSB width register
// returns to 8. The pattern memory needs no clearing, since entries are read
// only after they are written. Write csr_write_data only while idle.
// ----------------------------------------------------------------------------
module hevc_poc_gop_analyzer_unit #(
   parameter int unsigned GOP_PATTERN_DEPTH = 4096
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_en,
   input  logic [4:0]        csr_write_data,
   input  logic              req_valid,
   output logic              req_stall,
   input  hpga_pkg::req_type req,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output hpga_pkg::rsp_type rsp
);

   logic [4:0]          log2_ff, log2_in;
   logic                s1_valid_ff, s1_valid_in;
   hpga_pkg::req_type   s1_item_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   hpga_pkg::rsp_type   rsp_ff, rsp_in;

   hpga_pkg::ctl_type   ctl;
   hpga_pkg::stats_type stats_next;
   logic [31:0]         poc;
   logic                out_free;
   logic                s1_free;
   logic [1:0]          ftype;
   logic [1:0]          pred;
   logic [7:0]          flags;

   always_comb begin
      out_free   = !rsp_valid_ff || !rsp_stall;
      ctl.commit = s1_valid_ff && out_free;
      s1_free    = !s1_valid_ff || ctl.commit;
      ctl.accept = req_valid && s1_free;
      req_stall  = !s1_free;

      if (ctl.accept) begin
         s1_valid_in = 1'b1;
      end else if (ctl.commit) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      rsp_valid_in = ctl.commit || (rsp_valid_ff && rsp_stall);
      log2_in      = csr_write_en ? csr_write_data : log2_ff;

      ftype = hpga_pkg::norm_type(s1_item_ff.pic_class);
      unique case (ftype)
         hpga_pkg::FT_P: pred = hpga_pkg::PRED_P;
         hpga_pkg::FT_B: pred = hpga_pkg::PRED_B;
         default:        pred = hpga_pkg::PRED_I;
      endcase
      if (s1_item_ff.op == hpga_pkg::OP_EOS) begin
         flags = 8'd0;
      end else begin
         flags = {2'b00, pred, 2'b00, pred};
         if (s1_item_ff.is_idr) begin
            flags = flags | hpga_pkg::FLAG_IDR;
         end
      end

      rsp_in.poc               = poc;
      rsp_in.entry_flags       = flags;
      rsp_in.max_b_run         = stats_next.max_b_run;
      rsp_in.max_gop_size      = stats_next.max_gop_size;
      rsp_in.gop_unlimited     = stats_next.gop_unlimited;
      rsp_in.closed_gop        = stats_next.closed_gop;
      rsp_in.identical_gop     = stats_next.identical_gop;
      rsp_in.starts_with_intra = stats_next.starts_with_intra;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   hpga_poc_unit u_poc (
      .clock            (clock),
      .reset            (reset),
      .commit           (ctl.commit),
      .item             (s1_item_ff),
      .log2_max_poc_lsb (log2_ff),
      .poc              (poc)
   );

   hpga_gop_unit #(
      .DEPTH (GOP_PATTERN_DEPTH)
   ) u_gop (
      .clock         (clock),
      .reset         (reset),
      .ctl           (ctl),
      .req_pic_class (req.pic_class),
      .item          (s1_item_ff),
      .stats_next    (stats_next)
   );

   always_ff @(posedge clock) begin
      if (ctl.accept) begin
         s1_item_ff <= req;
      end
      if (ctl.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         log2_ff      <= hpga_pkg::LOG2_POC_RESET;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         log2_ff      <= log2_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef NO_ASSERTIONS
   // An accepted request always sits in the input register in the next cycle.
   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> s1_valid_ff)
      else $error("accepted request did not reach the input register");

   // An unlimited GOP reports a maximum size of zero.
   a_unlimited_size: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.gop_unlimited) |-> (rsp_ff.max_gop_size == 16'd0))
      else $error("unlimited GOP with nonzero maximum size");

   // Closed and identical marks never come back, and the longest B run never shrinks.
   a_sticky_stats: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && $past(rsp_valid_ff)) |->
         ((!rsp_ff.closed_gop || $past(rsp_ff.closed_gop)) &&
          (!rsp_ff.identical_gop || $past(rsp_ff.identical_gop)) &&
          (rsp_ff.max_b_run >= $past(rsp_ff.max_b_run))))
      else $error("GOP statistics moved backward");
`endif

endmodule

// File: verif/hevc_poc_gop_analyzer_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HEVC POC and GOP analyzer regression
// Sends parsed frame headers and end of stream markers through the request
// channel under random idling and stalling, predicts each response with an
// independent model of POC decode and GOP statistics, and compares every
// response field by field. The run also covers the LSB width register over
// its range and long B runs past the saturation point.
// ----------------------------------------------------------------------------
module hevc_poc_gop_analyzer_unit_test;

   localparam int GOP_DEPTH = 4096;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_write_en = 1'b0;
   logic [4:0]        csr_write_data = '0;
   logic              req_valid = 1'b0;
   logic              req_stall;
   hpga_pkg::req_type req = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   hpga_pkg::rsp_type rsp;

   hevc_poc_gop_analyzer_unit uut (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req            (req),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp            (rsp)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   hpga_pkg::req_type headers_to_send[$];
   hpga_pkg::rsp_type stats_due[$];
   int unsigned       send_gap_pct = 0;
   int unsigned       rsp_hold_pct = 0;
   int unsigned       errors = 0;
   hpga_pkg::rsp_type stats_want;

   // Analyzer state as the block should hold it.
   logic [4:0]  lsb_bits = hpga_pkg::LOG2_POC_RESET;
   logic [15:0] prev_lsb_q = '0;
   logic [31:0] prev_msb_q = '0;
   logic        have_prev_q = 1'b0;
   logic [31:0] frame_pos = '0;
   logic [31:0] group_base_pos = '0;
   logic [7:0]  b_run_q = '0;
   logic [7:0]  b_run_max_q = '0;
   logic [15:0] gop_max_q = '0;
   logic        unlimited_q = 1'b0;
   logic        closed_q = 1'b1;
   logic        intra_start_q = 1'b1;
   logic        identical_q = 1'b1;
   logic        first_gop_q = 1'b1;
   logic [1:0]  first_gop_types[GOP_DEPTH];
   int unsigned first_gop_len = 0;

   // Stimulus generator state.
   logic [1:0]  first_gop_kinds[$];
   logic        recording_first_gop = 1'b0;
   logic [15:0] lsb_run = '0;
   int          gop_left = 0;

   function automatic void settle_gop_size();
      logic [31:0] size;
      if (!unlimited_q) begin
         size = frame_pos - group_base_pos;
         if (size > hpga_pkg::GOP_SIZE_LIMIT) begin
            unlimited_q = 1'b1;
            gop_max_q = '0;
         end else if (size > {16'd0, gop_max_q}) begin
            gop_max_q = size[15:0];
         end
      end
   endfunction

   function automatic logic [31:0] poc_of(logic idr, logic [5:0] nal, logic [2:0] tid,
                                           logic [15:0] lsb);
      logic [32:0] modulus;
      logic [31:0] half, msb, lsb32, prev32;
      logic        ref_pic;
      if (idr) begin
         prev_lsb_q = '0;
         prev_msb_q = '0;
         have_prev_q = 1'b1;
         return '0;
      end
      modulus = '0;
      if (lsb_bits > 5'd0 && lsb_bits < hpga_pkg::LOG2_POC_BAD)
         modulus = 33'd1 << lsb_bits;
      half = modulus[32:1];
      lsb32 = {16'd0, lsb};
      prev32 = {16'd0, prev_lsb_q};
      if (!have_prev_q || modulus == '0)
         msb = '0;
      else if (lsb32 < prev32 && (prev32 - lsb32) >= half)
         msb = prev_msb_q + modulus[31:0];
      else if (lsb32 > prev32 && (lsb32 - prev32) > half)
         msb = prev_msb_q - modulus[31:0];
      else
         msb = prev_msb_q;
      // RASL, RADL and sub-layer non-reference pictures leave the history alone.
      ref_pic = (tid == 3'd0) && nal != hpga_pkg::NAL_RASL_N && nal != hpga_pkg::NAL_RASL_R
                && nal != hpga_pkg::NAL_RADL_N && nal != hpga_pkg::NAL_RADL_R
                && !(nal <= hpga_pkg::NAL_SLNR_MAX && !nal[0]);
      if (ref_pic) begin
         prev_lsb_q = lsb;
         prev_msb_q = msb;
         have_prev_q = 1'b1;
      end
      return msb + lsb32;
   endfunction

   function automatic hpga_pkg::rsp_type analyze_header(hpga_pkg::req_type h);
      hpga_pkg::rsp_type r;
      logic [1:0]        ft;
      logic [1:0]        code;
      logic              start;
      logic [31:0]       at;
      r = '0;
      if (h.op == hpga_pkg::OP_EOS) begin
         settle_gop_size();
      end else begin
         r.poc = poc_of(h.is_idr, h.nal_code, h.temporal_id, h.poc_lsb);
         ft = (h.pic_class == hpga_pkg::FT_UNKNOWN) ? hpga_pkg::FT_I : h.pic_class;
         start = (ft == hpga_pkg::FT_I);
         if (ft == hpga_pkg::FT_B) begin
            if (b_run_q != hpga_pkg::B_RUN_LIMIT)
               b_run_q = b_run_q + 8'd1;
            if (b_run_q > b_run_max_q)
               b_run_max_q = b_run_q;
         end else begin
            b_run_q = '0;
         end
         if (start)
            settle_gop_size();
         if (start && !h.is_idr)
            closed_q = 1'b0;
         if (frame_pos == '0 && !start)
            intra_start_q = 1'b0;
         if (!intra_start_q && start)
            identical_q = 1'b0;
         if (identical_q) begin
            if (first_gop_q && start && frame_pos != '0)
               first_gop_q = 1'b0;
            if (first_gop_q) begin
               if (first_gop_len < GOP_DEPTH) begin
                  first_gop_types[first_gop_len] = ft;
                  first_gop_len++;
               end
               if (first_gop_len >= GOP_DEPTH)
                  identical_q = 1'b0;
            end else begin
               at = start ? '0 : frame_pos - group_base_pos;
               if (at >= first_gop_len || first_gop_types[at] != ft)
                  identical_q = 1'b0;
            end
         end
         code = (ft == hpga_pkg::FT_I) ? hpga_pkg::PRED_I :
                (ft == hpga_pkg::FT_P) ? hpga_pkg::PRED_P : hpga_pkg::PRED_B;
         r.entry_flags = {2'b00, code, 2'b00, code};
         if (h.is_idr)
            r.entry_flags = r.entry_flags | hpga_pkg::FLAG_IDR;
         if (start)
            group_base_pos = frame_pos;
         if (frame_pos != hpga_pkg::FRAME_POS_MAX)
            frame_pos = frame_pos + 32'd1;
      end
      r.max_b_run = b_run_max_q;
      r.max_gop_size = gop_max_q;
      r.gop_unlimited = unlimited_q;
      r.closed_gop = closed_q;
      r.identical_gop = identical_q;
      r.starts_with_intra = intra_start_q;
      return r;
   endfunction

   // Request side: hold a stalled transfer, otherwise maybe idle.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            stats_due.insert(stats_due.size(), analyze_header(req));
         if (!req_valid || !req_stall) begin
            if (headers_to_send.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
               req <= headers_to_send.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_stall <= (rsp_hold_pct != 0) && ($urandom_range(99) < rsp_hold_pct);
   end

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected 0x%0h, actual 0x%0h", $time, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (stats_due.size() == 0) begin
            $display("%0t: response transfer with none predicted, poc 0x%0h",
                     $time, rsp.poc);
            errors++;
         end else begin
            stats_want = stats_due.pop_front();
            check_field("poc", 32'(stats_want.poc), 32'(rsp.poc));
            check_field("entry_flags", 32'(stats_want.entry_flags),
                        32'(rsp.entry_flags));
            check_field("max_b_run", 32'(stats_want.max_b_run), 32'(rsp.max_b_run));
            check_field("max_gop_size", 32'(stats_want.max_gop_size),
                        32'(rsp.max_gop_size));
            check_field("gop_unlimited", 32'(stats_want.gop_unlimited),
                        32'(rsp.gop_unlimited));
            check_field("closed_gop", 32'(stats_want.closed_gop), 32'(rsp.closed_gop));
            check_field("identical_gop", 32'(stats_want.identical_gop),
                        32'(rsp.identical_gop));
            check_field("starts_with_intra", 32'(stats_want.starts_with_intra),
                        32'(rsp.starts_with_intra));
         end
      end
   end

   function automatic hpga_pkg::req_type make_header(logic op, logic idr, logic [1:0] ft,
                                                     logic [5:0] nal, logic [2:0] tid,
                                                     logic [15:0] lsb);
      hpga_pkg::req_type h;
      h.op = op;
      h.is_idr = idr;
      h.pic_class = ft;
      h.nal_code = nal;
      h.temporal_id = tid;
      h.poc_lsb = lsb;
      return h;
   endfunction

   task automatic send_frame(logic idr, logic [1:0] ft, logic [5:0] nal, logic [2:0] tid,
                             logic [15:0] lsb);
      headers_to_send.insert(headers_to_send.size(),
                             make_header(hpga_pkg::OP_FRAME, idr, ft, nal, tid, lsb));
      if (recording_first_gop)
         first_gop_kinds.insert(first_gop_kinds.size(), ft);
   endtask

   // Mostly increasing LSBs that wrap at the configured modulus, with B-style
   // steps back and the odd jump anywhere.
   function automatic logic [15:0] next_poc_lsb();
      logic [15:0] mask;
      if ($urandom_range(9) == 0)
         return 16'($urandom_range(16'hFFFF));
      mask = (lsb_bits >= 5'd1 && lsb_bits <= 5'd15) ? (16'd1 << lsb_bits) - 16'd1
                                                    : 16'hFFFF;
      lsb_run = lsb_run + 16'($urandom_range(4, 1));
      return (lsb_run - 16'($urandom_range(2))) & mask;
   endfunction

   task automatic random_frame(logic [1:0] ft);
      logic [5:0] nal;
      logic [2:0] tid;
      nal = $urandom_range(1) ? 6'($urandom_range(63)) : 6'($urandom_range(9));
      tid = $urandom_range(1) ? 3'd0 : 3'($urandom_range(6));
      send_frame($urandom_range(6) == 0, ft, nal, tid, next_poc_lsb());
   endtask

   task automatic send_eos();
      hpga_pkg::req_type h;
      h = make_header(hpga_pkg::OP_EOS, 1'($urandom_range(1)), 2'($urandom_range(3)),
                      6'($urandom_range(63)), 3'($urandom_range(6)),
                      16'($urandom_range(16'hFFFF)));
      headers_to_send.insert(headers_to_send.size(), h);
   endtask

   task automatic send_noise();
      hpga_pkg::req_type h;
      h = make_header($urandom_range(9) == 0, 1'($urandom_range(1)),
                      2'($urandom_range(3)), 6'($urandom_range(63)),
                      3'($urandom_range(6)), 16'($urandom_range(16'hFFFF)));
      headers_to_send.insert(headers_to_send.size(), h);
   endtask

   // GOPs that are prefixes of the first one, so identical_gop stays up.
   task automatic first_gop_repeats(int n);
      int k;
      int len;
      k = 0;
      while (k < n) begin
         len = int'($urandom_range(first_gop_kinds.size(), 1));
         for (int i = 0; i < len; i++) begin
            if ($urandom_range(19) == 0) begin
               send_eos();
               k++;
            end
            if (i == 0)
               random_frame($urandom_range(1) ? hpga_pkg::FT_I : hpga_pkg::FT_UNKNOWN);
            else
               random_frame(first_gop_kinds[i]);
            k++;
         end
      end
   endtask

   task automatic stream_frames(int n);
      int unsigned r;
      for (int k = 0; k < n; k++) begin
         r = $urandom_range(99);
         if (r < 8) begin
            send_noise();
         end else if (r < 13) begin
            send_eos();
         end else if (gop_left == 0) begin
            random_frame($urandom_range(3) == 0 ? hpga_pkg::FT_UNKNOWN : hpga_pkg::FT_I);
            gop_left = int'($urandom_range(20));
         end else begin
            random_frame($urandom_range(1) ? hpga_pkg::FT_P : hpga_pkg::FT_B);
            gop_left--;
         end
      end
   endtask

   task automatic wait_idle();
      while (headers_to_send.size() != 0 || req_valid || stats_due.size() != 0)
         @(negedge clock);
   endtask

   task automatic set_lsb_bits(logic [4:0] bits);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_write_data <= bits;
      lsb_bits = bits;
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic run_phase(logic [4:0] bits, int unsigned gap, int unsigned hold, int n);
      wait_idle();
      send_gap_pct = gap;
      rsp_hold_pct = hold;
      set_lsb_bits(bits);
      stream_frames(n);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      send_gap_pct = 13;
      rsp_hold_pct = 64;
      set_lsb_bits(hpga_pkg::LOG2_POC_RESET);

      // The first GOP: IDR start, every picture class that skips the POC
      // history, wraps of the LSB both ways, an IDR P frame and the field
      // extremes.
      recording_first_gop = 1'b1;
      send_frame(1'b1, hpga_pkg::FT_I, 6'd19, 3'd0, 16'd0);
      send_frame(1'b0, hpga_pkg::FT_P, 6'd1, 3'd0, 16'd8);
      send_frame(1'b0, hpga_pkg::FT_B, 6'd0, 3'd0, 16'd4);
      send_frame(1'b0, hpga_pkg::FT_B, hpga_pkg::NAL_RASL_N, 3'd0, 16'd2);
      send_frame(1'b0, hpga_pkg::FT_B, hpga_pkg::NAL_RASL_R, 3'd0, 16'd3);
      send_frame(1'b0, hpga_pkg::FT_B, hpga_pkg::NAL_RADL_N, 3'd0, 16'd5);
      send_frame(1'b0, hpga_pkg::FT_B, hpga_pkg::NAL_RADL_R, 3'd0, 16'd6);
      headers_to_send.insert(headers_to_send.size(),
                             make_header(hpga_pkg::OP_EOS, 1'b1, hpga_pkg::FT_UNKNOWN,
                                         6'd63, 3'd6, 16'hFFFF));
      send_frame(1'b0, hpga_pkg::FT_P, 6'd1, 3'd6, 16'd200);
      send_frame(1'b0, hpga_pkg::FT_P, 6'd1, 3'd0, 16'd200);
      send_frame(1'b0, hpga_pkg::FT_P, 6'd63, 3'd0, 16'hFFFF);
      send_frame(1'b0, hpga_pkg::FT_P, 6'd1, 3'd0, 16'd0);
      send_frame(1'b1, hpga_pkg::FT_P, 6'd20, 3'd0, 16'd77);
      send_frame(1'b0, hpga_pkg::FT_B, hpga_pkg::NAL_SLNR_MAX, 3'd0, 16'h8000);
      send_frame(1'b0, hpga_pkg::FT_B, 6'd15, 3'd5, 16'h7FFF);
      send_frame(1'b0, hpga_pkg::FT_P, 6'd32, 3'd3, 16'h5555);
      send_frame(1'b0, hpga_pkg::FT_P, 6'd42, 3'd4, 16'hAAAA);
      recording_first_gop = 1'b0;
      // An unknown type opens the second GOP without IDR.
      send_frame(1'b0, hpga_pkg::FT_UNKNOWN, 6'd21, 3'd0, 16'd3);
      send_frame(1'b0, hpga_pkg::FT_P, 6'd1, 3'd0, 16'd9);
      send_frame(1'b0, hpga_pkg::FT_B, 6'd1, 3'd0, 16'd7);
      headers_to_send.insert(headers_to_send.size(),
                             make_header(hpga_pkg::OP_EOS, 1'b0, hpga_pkg::FT_I, 6'd0,
                                         3'd0, 16'd0));

      // Hold the sender until every response of the directed part is back.
      wait_idle();
      first_gop_repeats(200);
      repeat (60) send_noise();

      run_phase(5'd4, 13, 64, 110);
      run_phase(5'd16, 13, 64, 110);
      run_phase(5'd0, 64, 13, 100);
      run_phase(hpga_pkg::LOG2_POC_BAD, 64, 13, 100);
      run_phase(5'd1, 64, 13, 90);
      run_phase(5'd30, 0, 0, 90);
      run_phase(hpga_pkg::LOG2_POC_NOWRAP, 0, 0, 90);

      // A B run long enough to saturate the counter.
      run_phase(hpga_pkg::LOG2_POC_RESET, 0, 0, 0);
      repeat (270) random_frame(hpga_pkg::FT_B);
      random_frame(hpga_pkg::FT_I);
      send_eos();
      stream_frames(20);

      wait_idle();
      repeat (8) @(posedge clock);
      if (errors == 0 && stats_due.size() == 0) begin
         $display("hevc_poc_gop_analyzer_unit regression: pass");
      end else begin
         $display("hevc_poc_gop_analyzer_unit regression: fail");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("%0t: timeout", $time);
      $display("hevc_poc_gop_analyzer_unit regression: fail");
      $finish;
   end

endmodule
